// File: hdl/assert_macros.svh
// Assertion macros for the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/emb_pkg.sv
// Types, constants and the color ramp table of the emboss height map shader.
package emb_pkg;

  localparam int COORD_W   = 8;
  localparam int HEIGHT_W  = 8;
  localparam int MAP_DEPTH = 65536;
  localparam int LEVEL_W   = 6;
  localparam int COLOR_W   = 16;
  localparam int RAMP_SIZE = 64;
  localparam int RAMP_HALF = 32;

  localparam logic [7:0] LIGHT_RESET = 8'd128;
  localparam logic signed [17:0] LEVEL_BIAS = 18'sd32;
  localparam logic signed [17:0] LEVEL_MAX  = 18'sd63;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;

  localparam logic REG_LIGHT_X = 1'b0;
  localparam logic REG_LIGHT_Y = 1'b1;

  typedef struct packed {
    logic signed [7:0] gx;
    logic signed [7:0] gy;
    logic signed [8:0] wx;
    logic signed [8:0] wy;
  } emb_job_t;

  typedef logic [COLOR_W-1:0] ramp_rom_t [RAMP_SIZE];

  function automatic ramp_rom_t build_ramp();
    ramp_rom_t rom;
    int r;
    int g;
    int b;
    int k;
    for (int i = 0; i < RAMP_SIZE; i++) begin
      if (i < RAMP_HALF) begin
        r = (4049 - 111 * i) >> 5;
        g = (947 - 13 * i) >> 5;
        b = (13 + 13 * i) >> 5;
      end else begin
        k = i - RAMP_HALF;
        r = (608 + 19 * k) >> 5;
        g = (544 + 94 * k) >> 5;
        b = (416 + 92 * k) >> 5;
      end
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
      rom[i] = {5'(r >> 3), 6'(g >> 2), 5'(b >> 3)};
    end
    return rom;
  endfunction

  localparam ramp_rom_t RAMP = build_ramp();

endpackage

// File: hdl/emb_ram.sv
// Generic single write port, single read port RAM with registered read data.
module emb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/emb_front.sv
// Front end: light registers, item classification, height map writes and texel reads.
module emb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    func,
  input  logic [7:0]              col,
  input  logic [7:0]              row,
  input  logic [7:0]              height,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [7:0]              cfg_wdata,
  output logic                    job_valid,
  output emb_pkg::emb_job_t       job
);
  import emb_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  logic [7:0] light_x_r;
  logic [7:0] light_y_r;
  logic       job_valid_r;
  logic [8:0] wx_r;
  logic [8:0] wy_r;

  logic [7:0]    cx;
  logic [7:0]    cy;
  logic          wr_go;
  logic          shade_go;
  logic [AW-1:0] waddr;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addrx;
  logic [AW-1:0] addry;
  logic [7:0]    h0;
  logic [7:0]    hx;
  logic [7:0]    hy;
  logic [8:0]    wx_nxt;
  logic [8:0]    wy_nxt;

  assign cx       = ~col;
  assign cy       = ~row;
  assign wr_go    = accept && (func == FUNC_WRITE);
  assign shade_go = accept && (func == FUNC_SHADE);
  assign waddr    = {row, col};
  assign addr0    = {cy, cx};
  assign addrx    = {cy, cx + 8'd1};
  assign addry    = {cy + 8'd1, cx};
  assign wx_nxt   = {1'b0, ~light_x_r} - {1'b0, col};
  assign wy_nxt   = {1'b0, ~light_y_r} - {1'b0, row};

  emb_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_DEPTH)) u_ram_0 (
    .clk(clk), .we(wr_go), .waddr(waddr), .wdata(height), .raddr(addr0), .rdata(h0)
  );

  emb_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_DEPTH)) u_ram_x (
    .clk(clk), .we(wr_go), .waddr(waddr), .wdata(height), .raddr(addrx), .rdata(hx)
  );

  emb_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAP_DEPTH)) u_ram_y (
    .clk(clk), .we(wr_go), .waddr(waddr), .wdata(height), .raddr(addry), .rdata(hy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= LIGHT_RESET;
      light_y_r <= LIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LIGHT_X: light_x_r <= cfg_wdata;
        REG_LIGHT_Y: light_y_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= shade_go;
    end
  end

  always_ff @(posedge clk) begin
    if (shade_go) begin
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job.gx    = signed'(h0 - hx);
  assign job.gy    = signed'(h0 - hy);
  assign job.wx    = signed'(wx_r);
  assign job.wy    = signed'(wy_r);

endmodule

// File: hdl/emb_queue.sv
// Short job queue between the front end and the shading back end.
module emb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  emb_pkg::emb_job_t          job_in,
  input  logic                       pop,
  output emb_pkg::emb_job_t          job_out,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import emb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  emb_job_t        slot_r [DEPTH];
  logic [AW-1:0]   head_r;
  logic [AW-1:0]   tail_r;
  logic [CW-1:0]   count_r;
  logic [AW-1:0]   head_nxt;
  logic [AW-1:0]   tail_nxt;
  logic [CW-1:0]   count_nxt;
  logic            do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        tail_r <= tail_nxt;
      end
      if (do_pop) begin
        head_r <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= job_in;
    end
  end

  assign job_out = slot_r[head_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

// File: hdl/emb_back.sv
// Back end: gradient weighting, level clamp, ramp lookup and the result register.
module emb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_avail,
  input  emb_pkg::emb_job_t    job,
  output logic                 job_pop,
  input  logic                 res_pop,
  output logic                 res_valid,
  output logic [15:0]          color,
  output logic [5:0]           level
);
  import emb_pkg::*;

  logic                 p_valid_r;
  logic signed [16:0]   prod_x_r;
  logic signed [16:0]   prod_y_r;
  logic                 r_valid_r;
  logic [15:0]          color_r;
  logic [5:0]           level_r;

  logic                 r_load;
  logic                 p_load;
  logic signed [16:0]   prod_x_nxt;
  logic signed [16:0]   prod_y_nxt;
  logic signed [17:0]   sum;
  logic signed [17:0]   biased;
  logic [5:0]           level_nxt;

  assign r_load  = !r_valid_r || res_pop;
  assign p_load  = !p_valid_r || r_load;
  assign job_pop = job_avail && p_load;

  assign prod_x_nxt = 17'(job.gx) * 17'(job.wx);
  assign prod_y_nxt = 17'(job.gy) * 17'(job.wy);

  assign sum    = 18'(prod_x_r) + 18'(prod_y_r);
  assign biased = (sum >>> 5) + LEVEL_BIAS;

  always_comb begin
    priority if (biased < 18'sd0) begin
      level_nxt = '0;
    end else if (biased > LEVEL_MAX) begin
      level_nxt = LEVEL_MAX[5:0];
    end else begin
      level_nxt = biased[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
    end else begin
      if (p_load) begin
        p_valid_r <= job_pop;
      end
      if (r_load) begin
        r_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
    if (r_load && p_valid_r) begin
      level_r <= level_nxt;
      color_r <= RAMP[level_nxt];
    end
  end

  assign res_valid = r_valid_r;
  assign color     = color_r;
  assign level     = level_r;

endmodule

// File: hdl/emboss_height_map_shader.sv
// Top level of the emboss height map shader.
//
//   Port group  Direction  Handshake        Carries
//   in_         in         push / full      func, col, row, height
//   out_        out        pop / empty      color, level
//   cfg_        in         we (no wait)     light_x, light_y by index
//
// One item enters per cycle while in_full is low. A shade item goes through the texel
// read at its accepting edge, the job queue, the products, and the level and ramp
// register on the outputs. The three height RAM copies each have a write and read port.
// Reset is synchronous and clears control only; the height map keeps no reset.
// A stalled out_pop backs up the back end and the job queue, then raises in_full.
`include "assert_macros.svh"

module emboss_height_map_shader #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_height,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_color,
  output logic [5:0]  out_level,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata
);
  import emb_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] OCC_MAX = (CW + 1)'(QUEUE_DEPTH);

  logic          accept;
  logic          acc_write;
  logic          acc_shade;
  logic          job_valid;
  emb_job_t      job_front;
  emb_job_t      job_head;
  logic          q_empty;
  logic [CW-1:0] q_count;
  logic [CW:0]   occupancy;
  logic          job_pop;
  logic          res_valid;

  assign occupancy = {1'b0, q_count} + (CW + 1)'(job_valid);
  assign in_full   = (occupancy >= OCC_MAX);
  assign accept    = in_push && !in_full;
  assign acc_write = accept && (in_func == FUNC_WRITE);
  assign acc_shade = accept && (in_func == FUNC_SHADE);

  emb_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .func(in_func),
    .col(in_col),
    .row(in_row),
    .height(in_height),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .job_valid(job_valid),
    .job(job_front)
  );

  emb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(job_valid),
    .job_in(job_front),
    .pop(job_pop),
    .job_out(job_head),
    .empty(q_empty),
    .count(q_count)
  );

  emb_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .job_avail(!q_empty),
    .job(job_head),
    .job_pop(job_pop),
    .res_pop(out_pop),
    .res_valid(res_valid),
    .color(out_color),
    .level(out_level)
  );

  assign out_empty = !res_valid;

  `ASSERT_ALWAYS(a_queue_room, clk, rst_n, occupancy <= OCC_MAX, "job queue overrun")
  `ASSERT_NEXT(a_write_no_job, clk, rst_n, acc_write, !job_valid, "write item made a job")
  `ASSERT_NEXT(a_shade_job, clk, rst_n, acc_shade, job_valid, "shade item lost")

endmodule
